FILE: rtl/event_calendar_queue_unit_macros.svh
// Assertion macros used by the calendar queue unit.
`ifndef EVENT_CALENDAR_QUEUE_UNIT_MACROS_SVH
`define EVENT_CALENDAR_QUEUE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ECQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ecq_pkg.sv
`timescale 1ns / 1ps

package ecq_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_INSERTED = 2'd0;
    localparam t_status ST_REJECTED = 2'd1;
    localparam t_status ST_RELEASED = 2'd2;
    localparam t_status ST_NONE     = 2'd3;

    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // Upper bound on events released by one advance transaction.
    localparam int MAX_RESULTS = 16;
    localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        t_status     status;
        logic [31:0] seq_id;
        logic [15:0] out_job;
        logic [31:0] out_time;
        logic [15:0] out_priority;
        logic [31:0] now_time;
        logic        last;
    } t_result;

endpackage

FILE: rtl/event_calendar_queue_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake        Payload fields
// request  in   i_valid/o_stall  req_type, event_time, event_priority, job_tag, time_limit
// result   out  o_valid/i_stall  status, seq_id, out_job, out_time, out_priority, now_time, last
//
// Events live in a circular buffer in a one-port-read memory; one comparator walks it.
// An insert moves back, one place each, the stored events that the new event goes before.
// An advance releases due events in serving order and stops at the first one not due,
// at the end of the queue or at 16 events; a reject or an advance with nothing due yields one result.
// The next request is taken in the cycle after the last result reaches the output register.
// Reset (synchronous, active low) empties the queue; a result stall holds the walk in place.

`include "event_calendar_queue_unit_macros.svh"

module event_calendar_queue_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_event_time,
    input  logic [15:0] i_event_priority,
    input  logic [15:0] i_job_tag,
    input  logic [31:0] i_time_limit,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_seq_id,
    output logic [15:0] o_out_job,
    output logic [31:0] o_out_time,
    output logic [15:0] o_out_priority,
    output logic [31:0] o_now_time,
    output logic        o_last
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = ecq_pkg::CNT_BITS;
    localparam int EW = TIME_BITS + 64;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_CMP = 3'd1;
    localparam logic [2:0] S_INS_PUT = 3'd2;
    localparam logic [2:0] S_ADV_CMP = 3'd3;
    localparam logic [2:0] S_EMIT    = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [AW-1:0]        r_head, n_head;
    logic [OW-1:0]        r_occ, n_occ;
    logic [31:0]          r_next_seq, n_next_seq;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [AW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [TIME_BITS-1:0] r_key_time, n_key_time;
    logic [15:0]          r_key_prio, n_key_prio;
    logic [15:0]          r_key_job, n_key_job;
    ecq_pkg::t_result     r_pend, n_pend;
    ecq_pkg::t_result     r_out, n_out;
    logic                 r_o_valid, n_o_valid;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [EW-1:0]        w_wdata;
    logic [AW-1:0]        w_raddr;
    logic [EW-1:0]        w_rdata;
    logic [TIME_BITS-1:0] w_rd_time;
    logic [15:0]          w_rd_prio;
    logic [15:0]          w_rd_job;
    logic [31:0]          w_rd_seq;
    logic [EW-1:0]        w_new_entry;
    logic                 w_out_free;
    logic                 w_accept;
    logic                 w_goes_before;
    logic                 w_due;
    logic [CW-1:0]        w_cnt_inc;
    logic                 w_adv_stop;
    ecq_pkg::t_result     w_released;
    ecq_pkg::t_result     w_inserted;
    ecq_pkg::t_result     w_none;

    // Logical position in serving order to physical slot of the ring.
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [AW-1:0] offs);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= (AW + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (AW + 1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    ecq_store #(
        .DEPTH(QUEUE_DEPTH),
        .WIDTH(EW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rd_time   = w_rdata[EW-1:64];
    assign w_rd_prio   = w_rdata[63:48];
    assign w_rd_job    = w_rdata[47:32];
    assign w_rd_seq    = w_rdata[31:0];
    assign w_new_entry = {r_key_time, r_key_prio, r_key_job, r_next_seq};

    assign w_out_free = !r_o_valid || !i_stall;
    assign w_accept   = i_valid && (r_state == S_IDLE);

    // The new event goes in front of a stored one that is later, or equally timed
    // with a priority not above its own.
    assign w_goes_before = (w_rd_time > r_key_time) ||
                           ((w_rd_time == r_key_time) && (w_rd_prio <= r_key_prio));
    assign w_due      = (w_rd_time <= r_key_time);
    assign w_cnt_inc  = r_cnt + CW'(1);
    assign w_adv_stop = (32'(w_cnt_inc) == 32'(r_occ)) ||
                        (w_cnt_inc == CW'(ecq_pkg::MAX_RESULTS));

    always_comb begin
        w_released              = '0;
        w_released.status       = ecq_pkg::ST_RELEASED;
        w_released.seq_id       = w_rd_seq;
        w_released.out_job      = w_rd_job;
        w_released.out_time     = 32'(w_rd_time);
        w_released.out_priority = w_rd_prio;
        w_released.now_time     = 32'(w_rd_time);
        w_released.last         = w_adv_stop;

        w_inserted          = '0;
        w_inserted.status   = ecq_pkg::ST_INSERTED;
        w_inserted.seq_id   = r_next_seq;
        w_inserted.now_time = 32'(r_now);
        w_inserted.last     = 1'b1;

        w_none          = '0;
        w_none.status   = ecq_pkg::ST_NONE;
        w_none.now_time = 32'(r_now);
        w_none.last     = 1'b1;
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_occ      = r_occ;
        n_next_seq = r_next_seq;
        n_now      = r_now;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_key_time = r_key_time;
        n_key_prio = r_key_prio;
        n_key_job  = r_key_job;
        n_pend     = r_pend;
        n_out      = r_out;
        n_o_valid  = r_o_valid && i_stall;
        w_we       = 1'b0;
        w_waddr    = r_head;
        w_wdata    = w_new_entry;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key_prio = i_event_priority;
                    n_key_job  = i_job_tag;
                    n_cnt      = '0;
                    n_idx      = '0;
                    if (i_req_type == ecq_pkg::REQ_INSERT) begin
                        n_key_time = TIME_BITS'(i_event_time);
                        if (r_occ == OW'(QUEUE_DEPTH)) begin
                            n_pend          = w_none;
                            n_pend.status   = ecq_pkg::ST_REJECTED;
                            n_state         = S_EMIT;
                        end else if (r_occ == '0) begin
                            n_state = S_INS_PUT;
                        end else begin
                            n_idx   = AW'(r_occ - OW'(1));
                            n_state = S_INS_CMP;
                        end
                    end else begin
                        n_key_time = TIME_BITS'(i_time_limit);
                        if (r_occ == '0) begin
                            n_pend  = w_none;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_ADV_CMP;
                        end
                    end
                end
            end
            S_INS_CMP: begin
                w_we    = 1'b1;
                w_waddr = f_phys(r_head, r_idx + AW'(1));
                if (w_goes_before) begin
                    // Move this event one place back and look at the one ahead of it.
                    w_wdata = w_rdata;
                    if (r_idx == '0) begin
                        n_state = S_INS_PUT;
                    end else begin
                        n_idx = r_idx - AW'(1);
                    end
                end else begin
                    n_occ      = r_occ + OW'(1);
                    n_next_seq = r_next_seq + 32'd1;
                    n_pend     = w_inserted;
                    n_state    = S_EMIT;
                end
            end
            S_INS_PUT: begin
                w_we       = 1'b1;
                w_waddr    = r_head;
                n_occ      = r_occ + OW'(1);
                n_next_seq = r_next_seq + 32'd1;
                n_pend     = w_inserted;
                n_state    = S_EMIT;
            end
            S_ADV_CMP: begin
                if (w_due) begin
                    // The held event goes out here once the next one is known due; else it leaves as last from S_EMIT.
                    if ((r_cnt == '0) || w_out_free) begin
                        if (r_cnt != '0) begin
                            n_out      = r_pend;
                            n_o_valid  = 1'b1;
                        end
                        n_pend = w_released;
                        n_now  = w_rd_time;
                        n_cnt  = w_cnt_inc;
                        if (w_adv_stop) begin
                            n_head  = f_phys(r_head, AW'(w_cnt_inc));
                            n_occ   = r_occ - OW'(w_cnt_inc);
                            n_state = S_EMIT;
                        end else begin
                            n_idx = r_idx + AW'(1);
                        end
                    end
                end else if (r_cnt == '0) begin
                    n_pend  = w_none;
                    n_state = S_EMIT;
                end else begin
                    n_pend.last = 1'b1;
                    n_head      = f_phys(r_head, AW'(r_cnt));
                    n_occ       = r_occ - OW'(r_cnt);
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out     = r_pend;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The read address follows the next index, so the data matches r_idx.
    assign w_raddr = f_phys(r_head, n_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_occ      <= '0;
            r_next_seq <= '0;
            r_now      <= '0;
            r_idx      <= '0;
            r_cnt      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_occ      <= n_occ;
            r_next_seq <= n_next_seq;
            r_now      <= n_now;
            r_idx      <= n_idx;
            r_cnt      <= n_cnt;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_time <= n_key_time;
        r_key_prio <= n_key_prio;
        r_key_job  <= n_key_job;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_out.status;
    assign o_seq_id       = r_out.seq_id;
    assign o_out_job      = r_out.out_job;
    assign o_out_time     = r_out.out_time;
    assign o_out_priority = r_out.out_priority;
    assign o_now_time     = r_out.now_time;
    assign o_last         = r_out.last;

    `ECQ_ASSERT_SAME(a_occ_bound, 1'b1, r_occ <= OW'(QUEUE_DEPTH), "occupancy beyond depth")
    `ECQ_ASSERT_SAME(a_cnt_bound, r_state == S_ADV_CMP, r_cnt < CW'(ecq_pkg::MAX_RESULTS), "overrun")
    `ECQ_ASSERT_SAME(a_mid_release, r_o_valid && !r_out.last, r_out.status == ecq_pkg::ST_RELEASED, "mid")
    `ECQ_ASSERT_NEXT(a_busy_after_accept, w_accept, r_state != S_IDLE, "request taken without work")

endmodule

FILE: rtl/ecq_store.sv
`timescale 1ns / 1ps

module ecq_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/tb_event_calendar_queue_unit.sv
`timescale 1ns / 1ps

module tb_event_calendar_queue_unit;

    localparam int CAL_DEPTH    = 16;
    localparam int RANDOM_ITEMS = 240;
    localparam int QUIET_TAIL   = 40;
    localparam int HOLD_CYCLES  = 240;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int NUM_ROWS     = 16;

    typedef struct {
        logic             req;
        logic [31:0]      ev_time;
        logic [15:0]      ev_prio;
        logic [15:0]      job;
        logic [31:0]      limit;
        int               reps;
        bit               typed;
        ecq_pkg::t_result want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic        i_req_type       = 1'b0;
    logic [31:0] i_event_time     = '0;
    logic [15:0] i_event_priority = '0;
    logic [15:0] i_job_tag        = '0;
    logic [31:0] i_time_limit     = '0;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_seq_id;
    logic [15:0] o_out_job;
    logic [31:0] o_out_time;
    logic [15:0] o_out_priority;
    logic [31:0] o_now_time;
    logic        o_last;

    event_calendar_queue_unit #(
        .QUEUE_DEPTH(CAL_DEPTH),
        .TIME_BITS  (32)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_event_time    (i_event_time),
        .i_event_priority(i_event_priority),
        .i_job_tag       (i_job_tag),
        .i_time_limit    (i_time_limit),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_seq_id        (o_seq_id),
        .o_out_job       (o_out_job),
        .o_out_time      (o_out_time),
        .o_out_priority  (o_out_priority),
        .o_now_time      (o_now_time),
        .o_last          (o_last)
    );

    // Shadow copy of the calendar, kept in serving order.
    logic [31:0] cal_time [CAL_DEPTH];
    logic [15:0] cal_prio [CAL_DEPTH];
    logic [15:0] cal_job  [CAL_DEPTH];
    logic [31:0] cal_seq  [CAL_DEPTH];
    int          cal_count    = 0;
    logic [31:0] cal_next_seq = '0;
    logic [31:0] cal_now      = '0;

    ecq_pkg::t_result calendar_results_due[$];
    ecq_pkg::t_result head_result;
    int          errors       = 0;
    int          cycle_count  = 0;

    bit          idle_on      = 1'b1;
    bit          hold_req     = 1'b0;
    bit          hold_done    = 1'b0;
    int          hold_left    = 0;
    int          sink_burst_left  = 0;
    bit          sink_burst_stall = 1'b0;

    t_stim_row   directed_rows [NUM_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic ecq_pkg::t_result single_result(input ecq_pkg::t_status st,
                                                       input logic [31:0] seq,
                                                       input logic [31:0] now);
        ecq_pkg::t_result r;
        r          = '0;
        r.status   = st;
        r.seq_id   = seq;
        r.now_time = now;
        r.last     = 1'b1;
        return r;
    endfunction

    // Applies one request to the shadow calendar and queues the results it yields.
    function automatic void calendar_step(input logic req, input logic [31:0] ev_time,
                                          input logic [15:0] ev_prio, input logic [15:0] job,
                                          input logic [31:0] limit);
        int               i;
        int               pos;
        int               n;
        ecq_pkg::t_result r;
        if (req == ecq_pkg::REQ_INSERT) begin
            if (cal_count >= CAL_DEPTH) begin
                calendar_results_due.push_back(single_result(ecq_pkg::ST_REJECTED, '0,
                                                             cal_now));
                return;
            end
            pos = cal_count;
            // Walking backward leaves pos at the first entry that the new event precedes.
            for (i = cal_count - 1; i >= 0; i--) begin
                if (cal_time[i] > ev_time || (cal_time[i] == ev_time && cal_prio[i] <= ev_prio))
                    pos = i;
            end
            for (i = cal_count; i > pos; i--) begin
                cal_time[i] = cal_time[i-1];
                cal_prio[i] = cal_prio[i-1];
                cal_job[i]  = cal_job[i-1];
                cal_seq[i]  = cal_seq[i-1];
            end
            cal_time[pos] = ev_time;
            cal_prio[pos] = ev_prio;
            cal_job[pos]  = job;
            cal_seq[pos]  = cal_next_seq;
            calendar_results_due.push_back(single_result(ecq_pkg::ST_INSERTED, cal_next_seq,
                                                         cal_now));
            cal_next_seq = cal_next_seq + 32'd1;
            cal_count++;
        end else begin
            n = 0;
            while (n < cal_count && n < ecq_pkg::MAX_RESULTS && cal_time[n] <= limit)
                n++;
            if (n == 0) begin
                calendar_results_due.push_back(single_result(ecq_pkg::ST_NONE, '0, cal_now));
                return;
            end
            for (i = 0; i < n; i++) begin
                cal_now        = cal_time[i];
                r.status       = ecq_pkg::ST_RELEASED;
                r.seq_id       = cal_seq[i];
                r.out_job      = cal_job[i];
                r.out_time     = cal_time[i];
                r.out_priority = cal_prio[i];
                r.now_time     = cal_now;
                r.last         = (i == n - 1);
                calendar_results_due.push_back(r);
            end
            for (i = n; i < cal_count; i++) begin
                cal_time[i-n] = cal_time[i];
                cal_prio[i-n] = cal_prio[i];
                cal_job[i-n]  = cal_job[i];
                cal_seq[i-n]  = cal_seq[i];
            end
            cal_count -= n;
        end
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Presents one transaction and returns at the edge where it is taken.
    // Valid is only lowered when a gap follows, so it never toggles within a step.
    task automatic send_request(input logic req, input logic [31:0] ev_time,
                                input logic [15:0] ev_prio, input logic [15:0] job,
                                input logic [31:0] limit, input bit typed,
                                input ecq_pkg::t_result want);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_req_type       <= req;
        i_event_time     <= ev_time;
        i_event_priority <= ev_prio;
        i_job_tag        <= job;
        i_time_limit     <= limit;
        do @(posedge i_clk); while (o_stall);
        calendar_step(req, ev_time, ev_prio, job, limit);
        if (typed) begin
            void'(calendar_results_due.pop_back());
            calendar_results_due.push_back(want);
        end
    endtask

    // Result side: random stall bursts, one long hold-off, and none in the tail.
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!idle_on) begin
            i_stall <= 1'b0;
        end else begin
            if (sink_burst_left == 0) begin
                sink_burst_stall = ($urandom_range(0, 2) == 0);
                sink_burst_left  = $urandom_range(1, 15);
            end
            sink_burst_left--;
            i_stall <= sink_burst_stall;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (calendar_results_due.size() == 0) begin
                flag_error($sformatf("result with status %0d and seq %0h while none awaited",
                                     o_status, o_seq_id));
            end else begin
                head_result = calendar_results_due.pop_front();
                check_field("status", 32'(o_status), 32'(head_result.status));
                check_field("seq_id", o_seq_id, head_result.seq_id);
                check_field("out_job", 32'(o_out_job), 32'(head_result.out_job));
                check_field("out_time", o_out_time, head_result.out_time);
                check_field("out_priority", 32'(o_out_priority),
                            32'(head_result.out_priority));
                check_field("now_time", o_now_time, head_result.now_time);
                check_field("last", 32'(o_last), 32'(head_result.last));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        int          r;
        int          k;
        int          burst;
        int          random_sent;
        int          episode;
        logic [31:0] tick_base;
        logic [31:0] ev_t;
        logic [15:0] ev_p;
        logic [31:0] lim;

        // Empty calendar, ties at time zero and at 100, a limit below the current time,
        // an event earlier than the current time, a full store and a full release.
        directed_rows[0]  = '{ecq_pkg::REQ_ADVANCE, 32'h0, 16'h0, 16'h0, 32'h0, 1, 1'b1,
                              single_result(ecq_pkg::ST_NONE, 32'd0, 32'd0)};
        directed_rows[1]  = '{ecq_pkg::REQ_ADVANCE, 32'h0, 16'h0, 16'h0, 32'hFFFF_FFFF, 1, 1'b1,
                              single_result(ecq_pkg::ST_NONE, 32'd0, 32'd0)};
        directed_rows[2]  = '{ecq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'h0, 1,
                              1'b1, single_result(ecq_pkg::ST_INSERTED, 32'd0, 32'd0)};
        directed_rows[3]  = '{ecq_pkg::REQ_INSERT, 32'h0, 16'h0, 16'h0, 32'h0, 1, 1'b1,
                              single_result(ecq_pkg::ST_INSERTED, 32'd1, 32'd0)};
        directed_rows[4]  = '{ecq_pkg::REQ_INSERT, 32'h0, 16'hFFFF, 16'h1234, 32'h0, 1, 1'b1,
                              single_result(ecq_pkg::ST_INSERTED, 32'd2, 32'd0)};
        directed_rows[5]  = '{ecq_pkg::REQ_INSERT, 32'd100, 16'd7, 16'hAAAA, 32'h0, 1, 1'b1,
                              single_result(ecq_pkg::ST_INSERTED, 32'd3, 32'd0)};
        directed_rows[6]  = '{ecq_pkg::REQ_INSERT, 32'd100, 16'd7, 16'h5555, 32'h0, 1, 1'b1,
                              single_result(ecq_pkg::ST_INSERTED, 32'd4, 32'd0)};
        directed_rows[7]  = '{ecq_pkg::REQ_INSERT, 32'd100, 16'd8, 16'h0F0F, 32'h0, 1, 1'b1,
                              single_result(ecq_pkg::ST_INSERTED, 32'd5, 32'd0)};
        directed_rows[8]  = '{ecq_pkg::REQ_ADVANCE, 32'h0, 16'h0, 16'h0, 32'h0, 1, 1'b0, '0};
        directed_rows[9]  = '{ecq_pkg::REQ_ADVANCE, 32'h0, 16'h0, 16'h0, 32'd99, 1, 1'b1,
                              single_result(ecq_pkg::ST_NONE, 32'd0, 32'd0)};
        directed_rows[10] = '{ecq_pkg::REQ_ADVANCE, 32'h0, 16'h0, 16'h0, 32'd100, 1, 1'b0, '0};
        directed_rows[11] = '{ecq_pkg::REQ_ADVANCE, 32'h0, 16'h0, 16'h0, 32'd50, 1, 1'b1,
                              single_result(ecq_pkg::ST_NONE, 32'd0, 32'd100)};
        directed_rows[12] = '{ecq_pkg::REQ_INSERT, 32'd5, 16'd3, 16'hF0F0, 32'h0, 15, 1'b0, '0};
        directed_rows[13] = '{ecq_pkg::REQ_INSERT, 32'd5, 16'd3, 16'hF0F0, 32'h0, 1, 1'b1,
                              single_result(ecq_pkg::ST_REJECTED, 32'd0, 32'd100)};
        directed_rows[14] = '{ecq_pkg::REQ_ADVANCE, 32'h0, 16'h0, 16'h0, 32'hFFFF_FFFF, 1, 1'b0,
                              '0};
        directed_rows[15] = '{ecq_pkg::REQ_ADVANCE, 32'h0, 16'h0, 16'h0, 32'h0, 1, 1'b1,
                              single_result(ecq_pkg::ST_NONE, 32'd0, 32'hFFFF_FFFF)};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < NUM_ROWS; r++) begin
            repeat (directed_rows[r].reps)
                send_request(directed_rows[r].req, directed_rows[r].ev_time,
                             directed_rows[r].ev_prio, directed_rows[r].job,
                             directed_rows[r].limit, directed_rows[r].typed,
                             directed_rows[r].want);
        end

        // Episodes of clustered inserts followed by one or two advances, with noise mixed in.
        tick_base   = 32'd1000;
        random_sent = 0;
        episode     = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= RANDOM_ITEMS - QUIET_TAIL)
                idle_on = 1'b0;
            if (episode == 3)
                hold_req = 1'b1;
            tick_base = tick_base + $urandom_range(0, 25);
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 7);
            for (k = 0; k < burst; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_request(1'($urandom_range(0, 1)), $urandom, 16'($urandom),
                                 16'($urandom), $urandom, 1'b0, '0);
                end else begin
                    case ($urandom_range(0, 9))
                        0:       ev_t = $urandom;
                        1:       ev_t = 32'hFFFF_FFFF - $urandom_range(0, 3);
                        default: ev_t = tick_base + $urandom_range(0, 12);
                    endcase
                    ev_p = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3))
                                                      : 16'($urandom);
                    send_request(ecq_pkg::REQ_INSERT, ev_t, ev_p, 16'($urandom), $urandom,
                                 1'b0, '0);
                end
                random_sent++;
            end
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, 11))
                    0:       lim = $urandom;
                    1:       lim = 32'hFFFF_FFFF;
                    2:       lim = 32'h0;
                    default: lim = tick_base + $urandom_range(0, 15);
                endcase
                send_request(ecq_pkg::REQ_ADVANCE, $urandom, 16'($urandom), 16'($urandom),
                             lim, 1'b0, '0);
                random_sent++;
            end
            episode++;
        end
        i_valid <= 1'b0;

        while (calendar_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
